>>> hw/rtl/emb_pkg.sv
// shared types, constants and the emboss arithmetic of the emboss filter
package emb_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int CFG_W        = 13;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int LEN_W        = $clog2(MAX_WIDTH + 2);
   localparam int HLEN_W       = $clog2(HEIGHT_LIMIT + 1);
   localparam int PIX_W        = 24;
   localparam int ACC_W        = 12;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   // register indexes of the csr port
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // kernel, row-major
   localparam logic signed [ACC_W-1:0] EMBOSS_WEIGHT [9] = '{
      -12'sd2, -12'sd1, 12'sd0,
      -12'sd1, 12'sd1, 12'sd1,
      12'sd0, 12'sd1, 12'sd2
   };

   // one word handed from the front to the back
   typedef struct packed {
      logic             is_drain;
      logic             emit;
      logic             border;
      logic             frame_end;
      logic             use_mid;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } cmd_type;

   typedef logic [8:0][7:0] chan_window_type;

   function automatic logic [7:0] emboss_channel(chan_window_type p);
      logic signed [ACC_W-1:0] acc;
      logic [7:0]              res;
      acc = '0;
      for (int k = 0; k < 9; k++) begin
         acc = acc + EMBOSS_WEIGHT[k] * $signed(ACC_W'(p[k]));
      end
      if (acc < 0) begin
         res = 8'd0;
      end else if (acc > ACC_W'(255)) begin
         res = 8'd255;
      end else begin
         res = acc[7:0];
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/emboss_3x3_convolution.sv
// top level of the 3x3 emboss filter over a raster-order rgb pixel stream
//
// Takes one rgb word per clock in raster order while req_stall is low and returns
// each pixel of the frame once, width+1 accepted pixels after it went in: interior
// pixels get the emboss kernel -2 -1 0 / -1 1 1 / 0 1 2 per channel, clamped to
// 0..255, and pixels on the outer rows and columns pass through unchanged. Sustained
// rate is one word per cycle while rsp_stall is low, set by the single read and
// write port of each line store. At the earliest, rsp_valid rises once the word has
// passed the queue, the store read, the window update and then the emboss into the
// result register. After the last pixel of a frame, drain words (req_drain = 1) at
// frame start flush the remaining width+1 results, one per drain; drains elsewhere
// are dropped. rsp_frame_end marks the last pixel of a frame. The two line stores
// are 4096 x 24 bit memories that need no clearing after reset. image_width
// (index 0) and image_height (index 1) are clamped to 3..4096; a write restarts the
// frame and drops pending results, and must be made only while the block is idle.
module emboss_3x3_convolution (
   input  logic                      clock,
   input  logic                      reset,
   // pixel words in
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_red_in,
   input  logic [7:0]                req_green_in,
   input  logic [7:0]                req_blue_in,
   input  logic                      req_drain,
   // filtered words out
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_red_out,
   output logic [7:0]                rsp_green_out,
   output logic [7:0]                rsp_blue_out,
   output logic                      rsp_frame_end,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [emb_pkg::CFG_W-1:0] csr_data
);

   // front to queue
   logic             push;
   emb_pkg::cmd_type push_cmd;
   logic             queue_full;
   // queue to back
   logic             pop;
   emb_pkg::cmd_type head_cmd;
   logic             queue_not_empty;

   // front: counts positions, decides which words produce a result
   emb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .req_drain    (req_drain),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   // decouples input acceptance from output stalls
   emb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // back: line stores, window, kernel and result register
   emb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (head_cmd),
      .cmd_valid     (queue_not_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> hw/rtl/emb_queue.sv
// short command queue between the front and the back
module emb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  emb_pkg::cmd_type push_cmd,
   input  logic             pop,
   output emb_pkg::cmd_type head_cmd,
   output logic             not_empty,
   output logic             full
);

   emb_pkg::cmd_type                  entry_ff [emb_pkg::QUEUE_DEPTH];
   logic [emb_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [emb_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [emb_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == emb_pkg::QCNT_W'(emb_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

>>> hw/rtl/emb_front.sv
// front: csr registers, frame position counters and classification of each word
module emb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_red_in,
   input  logic [7:0]                req_green_in,
   input  logic [7:0]                req_blue_in,
   input  logic                      req_drain,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [emb_pkg::CFG_W-1:0] csr_data,
   input  logic                      queue_full,
   output logic                      push,
   output emb_pkg::cmd_type          push_cmd
);

   logic [emb_pkg::CFG_W-1:0]  width_ff, width_in;
   logic [emb_pkg::CFG_W-1:0]  height_ff, height_in;
   logic [emb_pkg::COL_W-1:0]  in_col_ff, in_col_in;
   logic [emb_pkg::ROW_W-1:0]  in_row_ff, in_row_in;
   logic [emb_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [emb_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [emb_pkg::LEN_W-1:0]  pending_ff, pending_in;

   logic [emb_pkg::CFG_W:0]    w_x, h_x;
   logic [emb_pkg::LEN_W-1:0]  w_eff, w_plus1, w_minus1;
   logic [emb_pkg::HLEN_W-1:0] h_eff, h_minus1;
   logic [emb_pkg::COL_W-1:0]  wm1;
   logic [emb_pkg::ROW_W-1:0]  hm1;
   logic                       accept, at_start, restart, emit_pix, drain_go;
   logic [emb_pkg::LEN_W-1:0]  pend_base;
   logic [emb_pkg::COL_W-1:0]  oc_base, oc_adv, ic_adv;
   logic [emb_pkg::ROW_W-1:0]  or_base, or_adv, ir_adv;
   logic                       out_last_col, out_last_row;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // clamp the programmed sizes
   always_comb begin
      w_x = {1'b0, width_ff};
      if (w_x < (emb_pkg::CFG_W + 1)'(3)) begin
         w_x = (emb_pkg::CFG_W + 1)'(3);
      end else if (w_x > (emb_pkg::CFG_W + 1)'(emb_pkg::MAX_WIDTH)) begin
         w_x = (emb_pkg::CFG_W + 1)'(emb_pkg::MAX_WIDTH);
      end
      h_x = {1'b0, height_ff};
      if (h_x < (emb_pkg::CFG_W + 1)'(3)) begin
         h_x = (emb_pkg::CFG_W + 1)'(3);
      end else if (h_x > (emb_pkg::CFG_W + 1)'(emb_pkg::HEIGHT_LIMIT)) begin
         h_x = (emb_pkg::CFG_W + 1)'(emb_pkg::HEIGHT_LIMIT);
      end
      w_eff    = w_x[emb_pkg::LEN_W-1:0];
      h_eff    = h_x[emb_pkg::HLEN_W-1:0];
      w_plus1  = w_eff + 1'b1;
      w_minus1 = w_eff - 1'b1;
      h_minus1 = h_eff - 1'b1;
      wm1      = w_minus1[emb_pkg::COL_W-1:0];
      hm1      = h_minus1[emb_pkg::ROW_W-1:0];
   end

   always_comb begin
      at_start = (in_col_ff == '0) && (in_row_ff == '0);
      // a pixel at frame start without a full backlog drops the old tail
      restart  = !req_drain && at_start && (pending_ff != w_plus1);
      drain_go = req_drain && at_start && (pending_ff != '0);

      pend_base = restart ? '0 : pending_ff;
      oc_base   = restart ? '0 : out_col_ff;
      or_base   = restart ? '0 : out_row_ff;
      emit_pix  = (pend_base == w_plus1);

      out_last_col = (oc_base == wm1);
      out_last_row = (or_base == hm1);
      oc_adv = out_last_col ? '0 : oc_base + 1'b1;
      or_adv = out_last_col ? (out_last_row ? '0 : or_base + 1'b1) : or_base;
      ic_adv = (in_col_ff == wm1) ? '0 : in_col_ff + 1'b1;
      ir_adv = (in_col_ff == wm1) ? ((in_row_ff == hm1) ? '0 : in_row_ff + 1'b1)
                                  : in_row_ff;

      push               = accept && (!req_drain || drain_go);
      push_cmd.is_drain  = req_drain;
      push_cmd.emit      = req_drain || emit_pix;
      push_cmd.border    = (or_base == '0) || out_last_row || (oc_base == '0) || out_last_col;
      push_cmd.frame_end = out_last_col && out_last_row;
      push_cmd.use_mid   = out_last_row;
      push_cmd.col       = req_drain ? oc_base : in_col_ff;
      push_cmd.pixel     = {req_red_in, req_green_in, req_blue_in};
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      if (csr_valid) begin
         unique case (csr_index)
            emb_pkg::REG_IMAGE_WIDTH:  width_in  = csr_data;
            emb_pkg::REG_IMAGE_HEIGHT: height_in = csr_data;
            default:                   width_in  = width_ff;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pending_in = '0;
      end else if (accept) begin
         if (req_drain) begin
            if (drain_go) begin
               out_col_in = oc_adv;
               out_row_in = or_adv;
               pending_in = pending_ff - 1'b1;
            end
         end else begin
            in_col_in = ic_adv;
            in_row_in = ir_adv;
            if (emit_pix) begin
               out_col_in = oc_adv;
               out_row_in = or_adv;
               pending_in = pend_base;
            end else begin
               out_col_in = oc_base;
               out_row_in = or_base;
               pending_in = pend_base + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= emb_pkg::WIDTH_RESET;
         height_ff  <= emb_pkg::HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pending_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pending_ff <= pending_in;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= w_plus1)
      else $error("backlog beyond one row plus one");

   a_drain_at_start: assert property (@(posedge clock) disable iff (reset)
      (push && req_drain) |-> (at_start && pending_ff != '0))
      else $error("drain word queued outside frame start");

endmodule

>>> hw/rtl/emb_back.sv
// back: line stores, 3x3 window, emboss arithmetic and the result register
module emb_back (
   input  logic             clock,
   input  logic             reset,
   input  emb_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_frame_end
);

   logic [emb_pkg::PIX_W-1:0] upper_mem  [emb_pkg::MAX_WIDTH];
   logic [emb_pkg::PIX_W-1:0] middle_mem [emb_pkg::MAX_WIDTH];
   logic [emb_pkg::PIX_W-1:0] up_rd_ff, mid_rd_ff;
   logic                      byp_hit_ff;
   logic [emb_pkg::PIX_W-1:0] byp_data_ff;

   logic                      s1_valid_ff;
   emb_pkg::cmd_type          s1_cmd_ff;
   logic                      s2_valid_ff, s2_drain_ff, s2_border_ff, s2_frame_end_ff;
   logic [emb_pkg::PIX_W-1:0] s2_drain_px_ff;

   logic [emb_pkg::PIX_W-1:0] window_ff [9];
   logic [emb_pkg::PIX_W-1:0] window_in [9];

   logic                      rsp_valid_ff;
   logic [emb_pkg::PIX_W-1:0] rsp_px_ff;
   logic                      rsp_frame_end_ff;

   logic                      advance, up_we;
   logic [emb_pkg::PIX_W-1:0] top_px, result_px;
   emb_pkg::chan_window_type  red_win, green_win, blue_win;

   // the whole back moves together; it halts only on a held result
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && cmd_valid;
   assign up_we   = advance && s1_valid_ff && !s1_cmd_ff.is_drain;
   assign top_px  = byp_hit_ff ? byp_data_ff : up_rd_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         mid_rd_ff <= middle_mem[cmd.col];
         if (!cmd.is_drain) begin
            middle_mem[cmd.col] <= cmd.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         up_rd_ff <= upper_mem[cmd.col];
      end
      if (up_we) begin
         upper_mem[s1_cmd_ff.col] <= mid_rd_ff;
      end
   end

   // read of the column that the older word writes this cycle
   always_ff @(posedge clock) begin
      if (advance) begin
         byp_hit_ff  <= up_we && pop && (s1_cmd_ff.col == cmd.col);
         byp_data_ff <= mid_rd_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         window_in[i] = window_ff[i];
      end
      if (up_we) begin
         for (int rr = 0; rr < 3; rr++) begin
            window_in[rr*3]     = window_ff[rr*3 + 1];
            window_in[rr*3 + 1] = window_ff[rr*3 + 2];
         end
         window_in[2] = top_px;
         window_in[5] = mid_rd_ff;
         window_in[8] = s1_cmd_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff && s1_cmd_ff.emit;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff        <= cmd;
         s2_drain_ff      <= s1_cmd_ff.is_drain;
         s2_border_ff     <= s1_cmd_ff.border;
         s2_frame_end_ff  <= s1_cmd_ff.frame_end;
         s2_drain_px_ff   <= s1_cmd_ff.use_mid ? mid_rd_ff : top_px;
         rsp_px_ff        <= result_px;
         rsp_frame_end_ff <= s2_frame_end_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         red_win[i]   = window_ff[i][23:16];
         green_win[i] = window_ff[i][15:8];
         blue_win[i]  = window_ff[i][7:0];
      end
      if (s2_drain_ff) begin
         result_px = s2_drain_px_ff;
      end else if (s2_border_ff) begin
         result_px = window_ff[4];
      end else begin
         result_px = {emb_pkg::emboss_channel(red_win),
                      emb_pkg::emboss_channel(green_win),
                      emb_pkg::emboss_channel(blue_win)};
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_px_ff[23:16];
   assign rsp_green_out = rsp_px_ff[15:8];
   assign rsp_blue_out  = rsp_px_ff[7:0];
   assign rsp_frame_end = rsp_frame_end_ff;

   a_no_pop_on_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("queue popped while result is held");

   a_drain_no_store_write: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_cmd_ff.is_drain) |-> !up_we)
      else $error("drain word wrote the upper line store");

endmodule
